@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// ante must be followed by cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// expr must never hold
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ sv/fbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpc_pkg
// Shared types and fixed constants of the frustum box/point cull block.
// ----------------------------------------------------------------------------
package fbpc_pkg;

	localparam int NORMAL_W    = 12;
	localparam int THRESH_W    = 28;
	localparam int NUM_PLANES  = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;

	// plane register layout
	localparam int NX_LSB     = 0;
	localparam int NY_LSB     = 12;
	localparam int NZ_LSB     = 24;
	localparam int BOX_THR_LSB = 36;

	// item kinds
	localparam logic KIND_BOX   = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_PLANE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PLANE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_PLANE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_PLANE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_PLANE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_NEAR_RIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_LEFT_TOP   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_BOTTOM     = 3'd7;

	// per plane: where its normal/box threshold and its point threshold live
	localparam logic [CFG_IDX_W-1:0] PLANE_REG_IDX [NUM_PLANES] = '{
		REG_NEAR_PLANE, REG_RIGHT_PLANE, REG_LEFT_PLANE, REG_TOP_PLANE, REG_BOTTOM_PLANE
	};
	localparam logic [CFG_IDX_W-1:0] POINT_REG_IDX [NUM_PLANES] = '{
		REG_POINT_NEAR_RIGHT, REG_POINT_NEAR_RIGHT, REG_POINT_LEFT_TOP,
		REG_POINT_LEFT_TOP, REG_POINT_BOTTOM
	};
	localparam int POINT_THR_LSB [NUM_PLANES] = '{0, 28, 0, 28, 0};

	// classification travelling with each item
	typedef struct packed {
		logic point;   // point test
		logic degen;   // box with low equal to high on every axis
	} ctl_t;

endpackage

@@ sv/fbpc_front.sv @@
// ----------------------------------------------------------------------------
// fbpc_front
// Input stage: accept an item, classify it and offer it to the queue.
// ----------------------------------------------------------------------------
module fbpc_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [COORD_WIDTH-1:0] lo_in [3],
	input  logic [COORD_WIDTH-1:0] hi_in [3],
	output logic                   push_valid,
	input  logic                   push_ready,
	output fbpc_pkg::ctl_t         ctl_out,
	output logic [COORD_WIDTH-1:0] lo_out [3],
	output logic [COORD_WIDTH-1:0] hi_out [3]
);

	logic                   v_s1;
	fbpc_pkg::ctl_t         ctl_s1;
	logic [COORD_WIDTH-1:0] lo_s1 [3];
	logic [COORD_WIDTH-1:0] hi_s1 [3];
	logic                   front_ready;
	fbpc_pkg::ctl_t         ctl_in;

	assign front_ready = !v_s1 || push_ready;
	assign in_stall    = !front_ready;

	always_comb begin
		ctl_in.point = (kind == fbpc_pkg::KIND_POINT);
		ctl_in.degen = (lo_in[0] == hi_in[0]) && (lo_in[1] == hi_in[1]) &&
			(lo_in[2] == hi_in[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (front_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && front_ready) begin
			ctl_s1 <= ctl_in;
			lo_s1  <= lo_in;
			hi_s1  <= hi_in;
		end
	end

	assign push_valid = v_s1;
	assign ctl_out    = ctl_s1;
	assign lo_out     = lo_s1;
	assign hi_out     = hi_s1;

endmodule

@@ sv/fbpc_fifo.sv @@
// ----------------------------------------------------------------------------
// fbpc_fifo
// Small flop-based queue between the classify front and the test back end.
// ----------------------------------------------------------------------------
module fbpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
		(wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign pop_data = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[AW-1:0]] <= push_data;
		end
	end

endmodule

@@ sv/fbpc_back.sv @@
// ----------------------------------------------------------------------------
// fbpc_back
// Plane tests: register all normal products, then reduce, compare and
// hold the verdict in the output register.
// ----------------------------------------------------------------------------
module fbpc_back #(
	parameter int COORD_WIDTH = 16,
	parameter int NP          = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  fbpc_pkg::ctl_t                      ctl_in,
	input  logic [COORD_WIDTH-1:0]              lo_in [3],
	input  logic [COORD_WIDTH-1:0]              hi_in [3],
	input  logic [fbpc_pkg::CFG_DATA_W-1:0]     plane_cfg [NP],
	input  logic [fbpc_pkg::THRESH_W-1:0]       point_thr [NP],
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                inside_res
);

	localparam int PW  = COORD_WIDTH + fbpc_pkg::NORMAL_W;
	localparam int SW  = PW + 2;
	localparam int CMW = (SW > fbpc_pkg::THRESH_W) ? SW : fbpc_pkg::THRESH_W;

	logic                 v_s1;
	fbpc_pkg::ctl_t       ctl_s1;
	logic signed [PW-1:0] plo_s1 [NP][3];
	logic signed [PW-1:0] phi_s1 [NP][3];
	logic                 out_valid_q;
	logic                 inside_q;
	logic                 out_ready;
	logic                 s1_ready;
	logic [NP-1:0]        pass;
	logic                 inside_d;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_ready  = !v_s1 || out_ready;
	assign q_pop     = q_valid && s1_ready;

	// Stage 1: six products per plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_s1 <= ctl_in;
			for (int p = 0; p < NP; p++) begin
				for (int a = 0; a < 3; a++) begin
					plo_s1[p][a] <= PW'($signed(lo_in[a])) * PW'($signed(
						plane_cfg[p][a*fbpc_pkg::NORMAL_W +: fbpc_pkg::NORMAL_W]));
					phi_s1[p][a] <= PW'($signed(hi_in[a])) * PW'($signed(
						plane_cfg[p][a*fbpc_pkg::NORMAL_W +: fbpc_pkg::NORMAL_W]));
				end
			end
		end
	end

	// Stage 2: best corner per axis for boxes, the point itself otherwise
	always_comb begin
		logic signed [PW-1:0]  term;
		logic signed [SW-1:0]  sum;
		logic signed [CMW-1:0] sum_x;
		logic signed [CMW-1:0] thr_x;
		for (int p = 0; p < NP; p++) begin
			sum = '0;
			for (int a = 0; a < 3; a++) begin
				if (ctl_s1.point || (plo_s1[p][a] > phi_s1[p][a])) term = plo_s1[p][a];
				else term = phi_s1[p][a];
				sum = sum + SW'(term);
			end
			sum_x = CMW'(sum);
			if (ctl_s1.point) begin
				thr_x = CMW'($signed(point_thr[p]));
			end else begin
				thr_x = CMW'($signed(plane_cfg[p][fbpc_pkg::BOX_THR_LSB +:
					fbpc_pkg::THRESH_W]));
			end
			pass[p] = (sum_x > thr_x);
		end
		inside_d = (&pass) || (!ctl_s1.point && ctl_s1.degen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && v_s1) begin
			inside_q <= inside_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

@@ sv/frustum_box_point_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_box_point_cull
// Tests an axis-aligned box or a point against up to five frustum planes.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  --------------------------------
//  in       sink       in_valid / in_stall   kind, x/y/z_low, x/y/z_high
//  out      source     out_valid / out_stall inside_res
//  config   sink       wr_en (no wait)       wr_index, wr_data
//
//  One item per cycle sustained while out_stall stays low; each item passes
//  through the front register, queue, product register and output
//  register. The product register with 6 multipliers per plane sets
//  the pace. Reset clears all valid flags and every configuration register.
//  A stall at the output fills the back end first, then the queue, and only
//  then raises in_stall.
//
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_box_point_cull #(
	parameter int PLANES      = 5,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [COORD_WIDTH-1:0]       x_low,
	input  logic signed [COORD_WIDTH-1:0]       y_low,
	input  logic signed [COORD_WIDTH-1:0]       z_low,
	input  logic signed [COORD_WIDTH-1:0]       x_high,
	input  logic signed [COORD_WIDTH-1:0]       y_high,
	input  logic signed [COORD_WIDTH-1:0]       z_high,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                inside_res,
	// configuration writes
	input  logic                                wr_en,
	input  logic [fbpc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [fbpc_pkg::CFG_DATA_W-1:0]     wr_data
);

	// planes beyond five are not defined; test at most five
	localparam int NP = (PLANES < fbpc_pkg::NUM_PLANES) ? PLANES : fbpc_pkg::NUM_PLANES;
	localparam int CTL_W = $bits(fbpc_pkg::ctl_t);
	localparam int QW    = CTL_W + 6 * COORD_WIDTH;

	// configuration registers, only for the planes that are tested
	logic [fbpc_pkg::CFG_DATA_W-1:0] plane_q [NP];
	logic [fbpc_pkg::THRESH_W-1:0]   point_thr_q [NP];

	logic [COORD_WIDTH-1:0] lo_in [3];
	logic [COORD_WIDTH-1:0] hi_in [3];
	logic [COORD_WIDTH-1:0] lo_f [3];
	logic [COORD_WIDTH-1:0] hi_f [3];
	logic [COORD_WIDTH-1:0] lo_b [3];
	logic [COORD_WIDTH-1:0] hi_b [3];
	fbpc_pkg::ctl_t         ctl_f;
	fbpc_pkg::ctl_t         ctl_b;
	logic                   push_valid;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_pop;
	logic [QW-1:0]          q_wdata;
	logic [QW-1:0]          q_rdata;

	// ---- configuration ----------------------------------------------------
	// Each plane picks its own register and, for point thresholds, its field.
	for (genvar p = 0; p < NP; p++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[p]     <= '0;
				point_thr_q[p] <= '0;
			end else if (wr_en) begin
				if (wr_index == fbpc_pkg::PLANE_REG_IDX[p]) begin
					plane_q[p] <= wr_data;
				end
				if (wr_index == fbpc_pkg::POINT_REG_IDX[p]) begin
					point_thr_q[p] <= wr_data[fbpc_pkg::POINT_THR_LSB[p] +:
						fbpc_pkg::THRESH_W];
				end
			end
		end
	end

	// ---- front: accept and classify ---------------------------------------
	assign lo_in[0] = x_low;
	assign lo_in[1] = y_low;
	assign lo_in[2] = z_low;
	assign hi_in[0] = x_high;
	assign hi_in[1] = y_high;
	assign hi_in[2] = z_high;

	fbpc_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.lo_in      (lo_in),
		.hi_in      (hi_in),
		.push_valid (push_valid),
		.push_ready (!q_full),
		.ctl_out    (ctl_f),
		.lo_out     (lo_f),
		.hi_out     (hi_f)
	);

	// ---- queue: decouple classify from test --------------------------------
	assign q_wdata = {ctl_f, lo_f[0], lo_f[1], lo_f[2], hi_f[0], hi_f[1], hi_f[2]};

	fbpc_fifo #(
		.WIDTH (QW),
		.DEPTH (fbpc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign {ctl_b, lo_b[0], lo_b[1], lo_b[2], hi_b[0], hi_b[1], hi_b[2]} = q_rdata;

	// ---- back: products, reduction, verdict --------------------------------
	fbpc_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.NP          (NP)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (!q_empty),
		.q_pop      (q_pop),
		.ctl_in     (ctl_b),
		.lo_in      (lo_b),
		.hi_in      (hi_b),
		.plane_cfg  (plane_q),
		.point_thr  (point_thr_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res)
	);

	// ---- checks -------------------------------------------------------------
	// A held front item facing a full queue must push back on the input.
	`ASSERT_IMPLIES(a_full_stalls_input, clk, arst_n, push_valid && q_full, in_stall)
	// Queue pointers never claim full and empty at once.
	`ASSERT_NEVER(a_queue_ptr_sane, clk, arst_n, q_full && q_empty)
	// Nothing is taken from an empty queue.
	`ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)

endmodule
